// ===== hw/rtl/pbd_pkg.sv =====
// Shared types and constants for the pulse beat detector.
package pbd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int SINCE_W    = 15;
    localparam int LEVEL_W    = 10;
    localparam int BPM_W      = 8;
    localparam int TICK_W     = 7;
    localparam int REFR_W     = 12;
    localparam int TIMEOUT_W  = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int PROD_W     = 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 2'd3;

    localparam logic [TICK_W-1:0]    RESET_TICK_MS    = 7'd2;
    localparam logic [REFR_W-1:0]    RESET_REFRACTORY = 12'd250;
    localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT    = 14'd2500;
    localparam logic [LEVEL_W-1:0]   RESET_LEVEL      = 10'd512;
    localparam logic [SINCE_W-1:0]   RESET_INTERVAL   = 15'd600;
    localparam logic [SINCE_W-1:0]   SINCE_MAX        = 15'd32767;

    // floor(x / 5) = (x * 26215) >> 17 for every 15-bit x
    localparam logic [PROD_W-1:0]    GAP_RECIP = 30'd26215;
    localparam int                   GAP_SHIFT = 17;

    localparam logic [15:0]          MS_PER_MINUTE = 16'd60000;
    // below this average, 60000 / average exceeds 255
    localparam logic [SINCE_W-1:0]   BPM_MIN_AVG   = 15'd235;
    localparam logic [BPM_W-1:0]     BPM_SAT       = 8'd255;

    typedef struct packed {
        logic [TICK_W-1:0]    tick_ms;
        logic [REFR_W-1:0]    refractory_ms;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [LEVEL_W-1:0]   default_level;
    } cfg_t;

    typedef struct packed {
        logic accept;     // capture sample, advance since-beat time
        logic eval;       // peak/trough tracking and beat test
        logic shift;      // push new interval into history, clear sum
        logic sum_step;   // add oldest entry, rotate history
        logic store_avg;  // latch sum / depth from the reciprocal product
        logic rate_sat;   // bpm saturates
        logic rate_load;  // bpm from divider
        logic finish;     // pulse end and timeout
        logic load_out;   // fill output register
    } cmd_t;

    typedef struct packed {
        logic beat;
        logic first;
        logic avg_small;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/pbd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pbd_div #(
    parameter int WIDTH = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dq_reg, dq_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_diff;

    assign rem_shift = {rem_reg, dq_reg[WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!rem_diff[WIDTH]) begin
                rem_next = rem_diff[WIDTH-1:0];
                dq_next  = {dq_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[WIDTH-1:0];
                dq_next  = {dq_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/pbd_ctrl.sv =====
// Sequencer that steps one sample word through the detector datapath.
module pbd_ctrl #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pbd_pkg::status_t     status,
    input  logic                 div_done,
    output logic                 div_start,
    output pbd_pkg::cmd_t        cmd
);

    localparam int CNT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EVAL   = 4'd1;
    localparam logic [3:0] ST_SHIFT  = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_DIV1   = 4'd4;
    localparam logic [3:0] ST_DIV2   = 4'd5;
    localparam logic [3:0] ST_WAIT2  = 4'd6;
    localparam logic [3:0] ST_FINISH = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.beat && status.first) begin
                    state_next = ST_OUT;
                end else if (status.beat) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HISTORY_DEPTH - 1)) begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                // average by reciprocal multiplication
                cmd.store_avg = 1'b1;
                state_next    = ST_DIV2;
            end
            ST_DIV2: begin
                if (status.avg_small) begin
                    cmd.rate_sat = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT2;
                end
            end
            ST_WAIT2: begin
                if (div_done) begin
                    cmd.rate_load = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register has room
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/pbd_datapath.sv =====
// Detector state, interval history, beat test and output register.
module pbd_datapath #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SUM_W         = 19
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pbd_pkg::cfg_t                   cfg,
    input  pbd_pkg::cmd_t                   cmd,
    output pbd_pkg::status_t                status,
    input  logic [pbd_pkg::SAMPLE_W-1:0]    sample,
    output logic [SUM_W-1:0]                div_dividend,
    output logic [SUM_W-1:0]                div_divisor,
    input  logic [SUM_W-1:0]                div_quotient,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pbd_pkg::BPM_W-1:0]       out_bpm,
    output logic [pbd_pkg::SINCE_W-1:0]     out_interval,
    output logic                            out_new_rate,
    output logic                            out_pulse_high,
    output logic [pbd_pkg::LEVEL_W-1:0]     out_level
);

    localparam int SW = pbd_pkg::SINCE_W;
    localparam int LW = pbd_pkg::LEVEL_W;

    // floor(sum / depth) = (sum * AVG_RECIP) >> AVG_SHIFT for every SUM_W-bit sum
    localparam int AVG_SHIFT  = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;
    localparam logic [AVG_SHIFT-1:0] AVG_RECIP = AVG_SHIFT'(
        ((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    logic [pbd_pkg::SAMPLE_W-1:0] sample_reg;
    logic [SW-1:0]                since_reg;
    logic [SW-1:0]                elapsed_reg;
    logic [SW-1:0]                interval_reg;
    logic [pbd_pkg::PROD_W-1:0]   prod_reg;
    logic [LW-1:0]                peak_reg;
    logic [LW-1:0]                trough_reg;
    logic [LW-1:0]                thr_reg;
    logic                         pulse_reg;
    logic                         first_reg;
    logic                         second_reg;
    logic [pbd_pkg::BPM_W-1:0]    rate_reg;
    logic                         fresh_reg;
    logic [SW-1:0]                hist_reg [HISTORY_DEPTH];
    logic [SUM_W-1:0]             acc_reg;
    logic [SW-1:0]                avg_reg;
    logic                         m_tvalid_reg;

    logic [SW:0]             since_sum;
    logic [SW-1:0]           elapsed_next;
    logic [SW-1:0]           gap_q;
    logic [SW-1:0]           gap_limit;
    logic                    past_gap;
    logic                    s_gt;
    logic                    s_lt;
    logic                    beat;
    logic                    pulse_end;
    logic                    timed_out;
    logic signed [LW:0]      amp;
    logic signed [LW:0]      half_amp;
    logic signed [LW:0]      new_thr;
    logic [AVG_PROD_W-1:0]   avg_prod;

    // saturating advance of the since-beat time
    assign since_sum    = {1'b0, since_reg} + {{(SW + 1 - pbd_pkg::TICK_W){1'b0}}, cfg.tick_ms};
    assign elapsed_next = since_sum[SW] ? pbd_pkg::SINCE_MAX : since_sum[SW-1:0];

    // three fifths of the last interval
    assign gap_q     = SW'(prod_reg[pbd_pkg::PROD_W-1:pbd_pkg::GAP_SHIFT]);
    assign gap_limit = gap_q + {gap_q[SW-2:0], 1'b0};
    assign past_gap  = elapsed_reg > gap_limit;

    assign s_gt = sample_reg > thr_reg;
    assign s_lt = sample_reg < thr_reg;
    assign beat = (elapsed_reg > {{(SW - pbd_pkg::REFR_W){1'b0}}, cfg.refractory_ms})
                  && s_gt && !pulse_reg && past_gap;

    assign pulse_end = s_lt && pulse_reg;
    assign timed_out = elapsed_reg > {{(SW - pbd_pkg::TIMEOUT_W){1'b0}}, cfg.timeout_ms};

    // new threshold: trough plus half the amplitude, halving toward zero
    assign amp      = $signed({1'b0, peak_reg}) - $signed({1'b0, trough_reg});
    assign half_amp = (amp + $signed({{LW{1'b0}}, amp[LW]})) >>> 1;
    assign new_thr  = half_amp + $signed({1'b0, trough_reg});

    assign avg_prod = AVG_PROD_W'(acc_reg) * AVG_PROD_W'(AVG_RECIP);

    assign div_dividend = SUM_W'(pbd_pkg::MS_PER_MINUTE);
    assign div_divisor  = SUM_W'(avg_reg);

    assign status.beat      = beat;
    assign status.first     = first_reg;
    assign status.avg_small = avg_reg < pbd_pkg::BPM_MIN_AVG;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_reg    <= '0;
            interval_reg <= pbd_pkg::RESET_INTERVAL;
            peak_reg     <= pbd_pkg::RESET_LEVEL;
            trough_reg   <= pbd_pkg::RESET_LEVEL;
            thr_reg      <= pbd_pkg::RESET_LEVEL;
            pulse_reg    <= 1'b0;
            first_reg    <= 1'b1;
            second_reg   <= 1'b0;
            rate_reg     <= '0;
            fresh_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                since_reg <= elapsed_next;
                fresh_reg <= 1'b0;
            end
            if (cmd.eval) begin
                if (s_lt && past_gap && (sample_reg < trough_reg)) begin
                    trough_reg <= sample_reg;
                end
                if (s_gt && (sample_reg > peak_reg)) begin
                    peak_reg <= sample_reg;
                end
                if (beat) begin
                    pulse_reg    <= 1'b1;
                    interval_reg <= elapsed_reg;
                    since_reg    <= '0;
                    if (second_reg) begin
                        second_reg <= 1'b0;
                    end
                    if (first_reg) begin
                        first_reg  <= 1'b0;
                        second_reg <= 1'b1;
                    end
                end
            end
            if (cmd.rate_sat) begin
                rate_reg  <= pbd_pkg::BPM_SAT;
                fresh_reg <= 1'b1;
            end
            if (cmd.rate_load) begin
                rate_reg  <= div_quotient[pbd_pkg::BPM_W-1:0];
                fresh_reg <= 1'b1;
            end
            if (cmd.finish) begin
                if (pulse_end) begin
                    pulse_reg <= 1'b0;
                end
                // timeout overrides the pulse-end levels
                if (timed_out) begin
                    thr_reg    <= cfg.default_level;
                    peak_reg   <= cfg.default_level;
                    trough_reg <= cfg.default_level;
                    since_reg  <= '0;
                    first_reg  <= 1'b1;
                    second_reg <= 1'b0;
                end else if (pulse_end) begin
                    thr_reg    <= new_thr[LW-1:0];
                    peak_reg   <= new_thr[LW-1:0];
                    trough_reg <= new_thr[LW-1:0];
                end
            end
        end
    end

    // working registers and history line
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg  <= sample;
            elapsed_reg <= elapsed_next;
            prod_reg    <= pbd_pkg::PROD_W'(interval_reg) * pbd_pkg::GAP_RECIP;
        end
        if (cmd.eval && beat && second_reg) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= elapsed_reg;
            end
        end
        if (cmd.shift) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= interval_reg;
            acc_reg <= '0;
        end
        if (cmd.sum_step) begin
            // rotate so every entry passes the adder once
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= hist_reg[0];
            acc_reg <= acc_reg + SUM_W'(hist_reg[0]);
        end
        if (cmd.store_avg) begin
            avg_reg <= avg_prod[AVG_SHIFT +: SW];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_bpm        <= rate_reg;
            out_interval   <= interval_reg;
            out_new_rate   <= fresh_reg;
            out_pulse_high <= pulse_reg;
            out_level      <= thr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hw/rtl/pulse_beat_detector.sv =====
// Pulse beat detector top level: configuration registers, sequencer, datapath, divider.
// Path of a sample word: evaluate, then output at once on a discarded first beat; finish and
// output on other ticks without a beat; after a beat, shift, history sum and reciprocal average,
// then bpm saturated or 60000 / average from the bit-serial divider, then finish and output.
// Throughput: one word in flight; the next is taken the cycle after its result is loaded.
// Reset (aresetn low, synchronous) restores register defaults and detector state.
module pulse_beat_detector #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [9:0] sample, [15:10] zero
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] bpm, [22:8] beat_interval, [23] pulse_high, [33:24] level, [39:34] zero
    output logic [39:0]                       m_tdata,
    output logic                              m_tuser,   // [0] new_rate
    // configuration write port
    input  logic                              cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // history sum needs room for HISTORY_DEPTH full-scale intervals
    localparam int SUM_W = pbd_pkg::SINCE_W + $clog2(HISTORY_DEPTH);

    pbd_pkg::cfg_t    cfg_reg;
    pbd_pkg::cmd_t    cmd;
    pbd_pkg::status_t status;

    logic                          div_start;
    logic                          div_done;
    logic [SUM_W-1:0]              div_dividend;
    logic [SUM_W-1:0]              div_divisor;
    logic [SUM_W-1:0]              div_quotient;
    logic [pbd_pkg::BPM_W-1:0]     out_bpm;
    logic [pbd_pkg::SINCE_W-1:0]   out_interval;
    logic                          out_new_rate;
    logic                          out_pulse_high;
    logic [pbd_pkg::LEVEL_W-1:0]   out_level;

    // configuration registers: take a write on every enabled edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_ms       <= pbd_pkg::RESET_TICK_MS;
            cfg_reg.refractory_ms <= pbd_pkg::RESET_REFRACTORY;
            cfg_reg.timeout_ms    <= pbd_pkg::RESET_TIMEOUT;
            cfg_reg.default_level <= pbd_pkg::RESET_LEVEL;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pbd_pkg::CFG_TICK_MS: begin
                    cfg_reg.tick_ms <= cfg_wdata[pbd_pkg::TICK_W-1:0];
                end
                pbd_pkg::CFG_REFRACTORY_MS: begin
                    cfg_reg.refractory_ms <= cfg_wdata[pbd_pkg::REFR_W-1:0];
                end
                pbd_pkg::CFG_TIMEOUT_MS: begin
                    cfg_reg.timeout_ms <= cfg_wdata[pbd_pkg::TIMEOUT_W-1:0];
                end
                pbd_pkg::CFG_DEFAULT_LEVEL: begin
                    cfg_reg.default_level <= cfg_wdata[pbd_pkg::LEVEL_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // sequencer: walks each sample word through evaluate and, as needed, average, finish and output steps
    pbd_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .status    (status),
        .div_done  (div_done),
        .div_start (div_start),
        .cmd       (cmd)
    );

    // datapath: detector state, history line and the output register
    pbd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_W         (SUM_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .sample         (s_tdata[pbd_pkg::SAMPLE_W-1:0]),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_quotient   (div_quotient),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_bpm        (out_bpm),
        .out_interval   (out_interval),
        .out_new_rate   (out_new_rate),
        .out_pulse_high (out_pulse_high),
        .out_level      (out_level)
    );

    // divider: 60000 by the history average
    pbd_div #(
        .WIDTH (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // pack the result word, lowest field first
    assign m_tdata = {6'b0, out_level, out_pulse_high, out_interval, out_bpm};
    assign m_tuser = out_new_rate;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pulse beat detector: beat predictor, scoreboard and drivers.
module tb_top;

    localparam int HISTORY_DEPTH  = 10;
    localparam int MISMATCH_SHOWN = 10;
    localparam int SETTLE_CYCLES  = 64;
    // Limit on the whole run, in ns, for the watchdog below.
    localparam int RUN_LIMIT_NS   = 20_000_000;

    localparam logic [pbd_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
        pbd_pkg::CFG_TICK_MS, pbd_pkg::CFG_REFRACTORY_MS, pbd_pkg::CFG_TIMEOUT_MS,
        pbd_pkg::CFG_DEFAULT_LEVEL
    };

    // Opening word sequence, run at tick 100 ms, no refractory, 700 ms timeout:
    // both sample extremes, a sample equal to the threshold, the discarded first beat,
    // the beat that seeds the history, two averaged beats, pulse ends, then a flat
    // stretch long enough to time out and a full-scale sample after it.
    localparam int DIRECTED_SAMPLES [26] = '{
        0, 1023, 512, 341, 682, 0, 0, 0, 1023, 0, 0, 0, 900,
        0, 0, 0, 1000, 10, 10, 10, 10, 10, 10, 10, 10, 1023
    };

    // idling modes of a random phase
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One result word as the block reports it.
    typedef struct packed {
        logic [pbd_pkg::BPM_W-1:0]   bpm;
        logic [pbd_pkg::SINCE_W-1:0] beat_interval;
        logic                        new_rate;
        logic                        pulse_high;
        logic [pbd_pkg::LEVEL_W-1:0] level;
    } readout_t;

    // Beat tracker: mirrors the detector state, holds the readouts still owed by the
    // block and checks each arriving result word against the oldest of them.
    class beat_book;
        int tick_ms, refractory_ms, timeout_ms, default_level;
        int since_ms, last_interval, peak_lvl, trough_lvl, thresh_lvl, bpm_now;
        int interval_log [HISTORY_DEPTH];
        bit in_pulse, await_first, await_seed;
        readout_t owed_q [$];
        int failures, shown, samples, fresh_rates, seeds, timeouts;

        function new();
            tick_ms       = pbd_pkg::RESET_TICK_MS;
            refractory_ms = pbd_pkg::RESET_REFRACTORY;
            timeout_ms    = pbd_pkg::RESET_TIMEOUT;
            default_level = pbd_pkg::RESET_LEVEL;
            since_ms      = 0;
            last_interval = pbd_pkg::RESET_INTERVAL;
            peak_lvl      = pbd_pkg::RESET_LEVEL;
            trough_lvl    = pbd_pkg::RESET_LEVEL;
            thresh_lvl    = pbd_pkg::RESET_LEVEL;
            bpm_now       = 0;
            in_pulse      = 1'b0;
            await_first   = 1'b1;
            await_seed    = 1'b0;
            foreach (interval_log[i]) interval_log[i] = 0;
            failures = 0;
            shown = 0;
            samples = 0;
            fresh_rates = 0;
            seeds = 0;
            timeouts = 0;
        endfunction

        function void set_register(logic [pbd_pkg::CFG_IDX_W-1:0] idx, int value);
            case (idx)
                pbd_pkg::CFG_TICK_MS:
                    tick_ms = value & ((1 << pbd_pkg::TICK_W) - 1);
                pbd_pkg::CFG_REFRACTORY_MS:
                    refractory_ms = value & ((1 << pbd_pkg::REFR_W) - 1);
                pbd_pkg::CFG_TIMEOUT_MS:
                    timeout_ms = value & ((1 << pbd_pkg::TIMEOUT_W) - 1);
                pbd_pkg::CFG_DEFAULT_LEVEL:
                    default_level = value & ((1 << pbd_pkg::LEVEL_W) - 1);
                default: ;
            endcase
        endfunction

        function void owe_readout(bit fresh);
            readout_t r;
            r.bpm           = bpm_now[pbd_pkg::BPM_W-1:0];
            r.beat_interval = last_interval[pbd_pkg::SINCE_W-1:0];
            r.new_rate      = fresh;
            r.pulse_high    = in_pulse;
            r.level         = thresh_lvl[pbd_pkg::LEVEL_W-1:0];
            owed_q.push_back(r);
        endfunction

        function void note_sample(logic [pbd_pkg::SAMPLE_W-1:0] smp);
            int s;
            int elapsed;
            int total;
            int avg;
            int amp;
            bit past_gap;
            bit fresh;
            s = smp;
            fresh = 1'b0;
            samples++;
            // advance elapsed time first; every test of this tick sees the advanced value
            since_ms = since_ms + tick_ms;
            if (since_ms > pbd_pkg::SINCE_MAX) since_ms = pbd_pkg::SINCE_MAX;
            elapsed = since_ms;
            past_gap = elapsed > (last_interval / 5) * 3;

            if (s < thresh_lvl && past_gap && s < trough_lvl) trough_lvl = s;
            if (s > thresh_lvl && s > peak_lvl) peak_lvl = s;

            if (elapsed > refractory_ms && s > thresh_lvl && !in_pulse && past_gap) begin
                in_pulse = 1'b1;
                last_interval = elapsed;
                since_ms = 0;
                if (await_seed) begin
                    await_seed = 1'b0;
                    seeds++;
                    foreach (interval_log[i]) interval_log[i] = last_interval;
                end
                // first beat: keep the interval, skip pulse end and timeout
                if (await_first) begin
                    await_first = 1'b0;
                    await_seed = 1'b1;
                    owe_readout(1'b0);
                    return;
                end
                total = 0;
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    interval_log[i] = interval_log[i + 1];
                    total += interval_log[i];
                end
                interval_log[HISTORY_DEPTH - 1] = last_interval;
                total += last_interval;
                avg = total / HISTORY_DEPTH;
                if (avg == 0 || pbd_pkg::MS_PER_MINUTE / avg > pbd_pkg::BPM_SAT) begin
                    bpm_now = pbd_pkg::BPM_SAT;
                end else begin
                    bpm_now = pbd_pkg::MS_PER_MINUTE / avg;
                end
                fresh = 1'b1;
                fresh_rates++;
            end

            if (s < thresh_lvl && in_pulse) begin
                amp = peak_lvl - trough_lvl;
                in_pulse = 1'b0;
                thresh_lvl = amp / 2 + trough_lvl;
                peak_lvl = thresh_lvl;
                trough_lvl = thresh_lvl;
            end

            // timeout uses the time before any beat of this tick cleared it
            if (elapsed > timeout_ms) begin
                thresh_lvl = default_level;
                peak_lvl = default_level;
                trough_lvl = default_level;
                since_ms = 0;
                await_first = 1'b1;
                await_seed = 1'b0;
                timeouts++;
            end

            owe_readout(fresh);
        endfunction

        function void flag(string msg);
            failures++;
            if (shown < MISMATCH_SHOWN) begin
                shown++;
                $display("[%0t] %s", $time, msg);
            end
        endfunction

        function void check_result(logic [39:0] tdata, logic tuser);
            readout_t got;
            readout_t want;
            got.bpm           = tdata[7:0];
            got.beat_interval = tdata[22:8];
            got.pulse_high    = tdata[23];
            got.level         = tdata[33:24];
            got.new_rate      = tuser;
            if (owed_q.size() == 0) begin
                flag($sformatf("result word with no sample pending: bpm %0d interval %0d",
                               got.bpm, got.beat_interval));
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                flag($sformatf({"readout mismatch: expected bpm %0d interval %0d rate %0b ",
                                "pulse %0b level %0d, got bpm %0d interval %0d rate %0b ",
                                "pulse %0b level %0d"},
                               want.bpm, want.beat_interval, want.new_rate, want.pulse_high,
                               want.level, got.bpm, got.beat_interval, got.new_rate,
                               got.pulse_high, got.level));
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [39:0]                    m_tdata;
    logic                           m_tuser;
    logic                           cfg_we    = 1'b0;
    logic [pbd_pkg::CFG_IDX_W-1:0]  cfg_index = pbd_pkg::CFG_TICK_MS;
    logic [pbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    beat_book book;

    // idle percentages of the sender and the receiver for the running phase
    int tx_pct = 0;
    int rx_pct = 0;
    int settings_run = 0;

    // synthetic pulse wave: one period is a short rise above the level, then a low stretch
    int wave_pos, wave_period, wave_rise, wave_lo, wave_hi;
    int per_min, per_max;

    pulse_beat_detector #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: check every accepted result word, then pick the next stall state.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            book.check_result(m_tdata, m_tuser);
        end
        m_tready <= ($urandom_range(99) >= rx_pct);
    end

    // Next sample of the pulse wave, with noise words and the odd flat stretch mixed in.
    function automatic logic [pbd_pkg::SAMPLE_W-1:0] next_wave_sample();
        int v;
        if (wave_pos >= wave_period) begin
            wave_pos = 0;
            wave_period = $urandom_range(per_max, per_min);
            // now and then stay flat long enough to reach the timeout
            if ($urandom_range(99) < 5) wave_period = wave_period * 4;
            wave_rise = $urandom_range(wave_period / 3 + 1, 1);
            wave_lo = $urandom_range(400, 0);
            wave_hi = $urandom_range(1023, 600);
        end
        if ($urandom_range(99) < 12) v = $urandom_range(1023, 0);
        else if (wave_pos < wave_rise) v = wave_hi - $urandom_range(40, 0);
        else v = wave_lo + $urandom_range(40, 0);
        wave_pos++;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[pbd_pkg::SAMPLE_W-1:0];
    endfunction

    // Offer one sample word, idling first at the sender's rate; return once accepted.
    task automatic send_sample(input logic [pbd_pkg::SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_sample(smp);
    endtask

    // Write all four registers on consecutive edges; hold the write enable high throughout.
    task automatic apply_settings(input int tick, input int refr, input int tmo,
                                  input int dflt);
        int vals [4];
        vals = '{tick, refr, tmo, dflt};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i][pbd_pkg::CFG_DATA_W-1:0];
            @(posedge aclk);
            book.set_register(REG_ORDER[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Hold off the sender until every owed readout has come back.
    task automatic drain();
        while (book.owed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One random phase: new register values, a wave shape, an idling mode, n sample words.
    task automatic run_phase(input int tick, input int refr, input int tmo, input int dflt,
                             input int pmin, input int pmax, input int n,
                             input idle_mode_t mode);
        apply_settings(tick, refr, tmo, dflt);
        per_min = pmin;
        per_max = pmax;
        wave_pos = 0;
        wave_period = 0;
        case (mode)
            IDLE_SENDER: begin
                tx_pct = 55;
                rx_pct = 0;
            end
            IDLE_RECEIVER: begin
                tx_pct = 0;
                rx_pct = 55;
            end
            IDLE_BOTH: begin
                tx_pct = 23;
                rx_pct = 23;
            end
            default: begin
                tx_pct = 0;
                rx_pct = 0;
            end
        endcase
        repeat (n) send_sample(next_wave_sample());
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        book = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening, no idling
        apply_settings(100, 0, 700, pbd_pkg::RESET_LEVEL);
        foreach (DIRECTED_SAMPLES[i]) begin
            send_sample(DIRECTED_SAMPLES[i][pbd_pkg::SAMPLE_W-1:0]);
        end
        s_tvalid <= 1'b0;
        drain();

        // random phases; register extremes, short and long intervals, frequent timeouts
        run_phase(20,  250,  2500,  512,  25, 45,  190, IDLE_NONE);
        run_phase(1,   0,    16383, 0,    2,  12,  190, IDLE_SENDER);
        run_phase(100, 4095, 16383, 1023, 45, 60,  190, IDLE_RECEIVER);
        run_phase(127, 300,  0,     600,  5,  10,  150, IDLE_BOTH);
        run_phase(50,  200,  1500,  300,  8,  40,  190, IDLE_SENDER);
        run_phase(0,   0,    5000,  512,  2,  6,   40,  IDLE_RECEIVER);
        run_phase(7,   400,  3000,  700,  60, 120, 220, IDLE_BOTH);
        run_phase(30,  100,  8000,  512,  10, 30,  190, IDLE_NONE);

        // let any stray word surface before the final count
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (book.owed_q.size() != 0) book.flag("readouts still owed at end of run");

        $display("covered %0d samples under %0d register settings", book.samples,
                 settings_run);
        $display("saw %0d fresh rates, %0d seeded histories, %0d timeouts, %0d failures",
                 book.fresh_rates, book.seeds, book.timeouts, book.failures);
        if (book.failures == 0) begin
            $display("pulse_beat_detector verification clean");
        end else begin
            $display("pulse_beat_detector verification failed");
        end
        $finish;
    end

    // watchdog: stop a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("pulse_beat_detector verification failed");
        $finish;
    end

endmodule
